// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Operation and status codes, the data width and the command that the
// controller broadcasts to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned SpqDataW   = 32;
  localparam int unsigned SpqDepth   = 128;
  localparam int unsigned SpqCountW  = 8;

  typedef enum logic [1:0] {
    OpEnqueue = 2'd0,
    OpDequeue = 2'd1,
    OpPeek    = 2'd2,
    OpClear   = 2'd3
  } spq_op_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } spq_status_e;

  // Command broadcast to all cells in the cycle an item is accepted.
  typedef struct packed {
    logic                shift_in;   // insert value, push smaller entries back
    logic                shift_out;  // drop head, pull entries forward
    logic [SpqDataW-1:0] value;      // value to insert
  } spq_cmd_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry; on insert it keeps, takes the new value or takes its
// left neighbor's entry; on removal it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int unsigned Index  = 0,
  parameter int unsigned CountW = 8
) (
  input  logic                         clk_i,
  input  spq_pkg::spq_cmd_t            cmd_i,
  input  logic [CountW-1:0]            count_i,
  input  logic                         left_gt_i,
  input  logic [spq_pkg::SpqDataW-1:0] left_val_i,
  input  logic [spq_pkg::SpqDataW-1:0] right_val_i,
  output logic                         gt_o,
  output logic [spq_pkg::SpqDataW-1:0] val_o
);
  import spq_pkg::*;

  logic [SpqDataW-1:0] val_q, val_d;
  logic                occupied;

  assign occupied = count_i > CountW'(Index);

  // New value goes at or before this slot when it beats the held entry,
  // or when the slot holds nothing.
  assign gt_o = !occupied || ($signed(cmd_i.value) > $signed(val_q));

  always_comb begin
    val_d = val_q;
    if (cmd_i.shift_in) begin
      if (gt_o && left_gt_i) begin
        val_d = left_val_i;
      end else if (gt_o) begin
        val_d = cmd_i.value;
      end
    end else if (cmd_i.shift_out) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit: descending priority queue on a chain of cells
// Results are registered: an accepted item's result reaches the master side in the next cycle.
// Throughput: one item per cycle; every cell shifts in the same cycle.
// The slave side stalls only while a result waits on a stalled master side.
// Reset: count and output valid clear at once; cell contents stay undefined
// and are never read past the count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
  parameter int unsigned Depth = spq_pkg::SpqDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value_in
  input  logic [1:0]  s_axis_tuser,   // [1:0] operation
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [1:0] status, [33:2] value_out,
                                      // [41:34] entry_count, [42] is_empty,
                                      // [43] is_full, [47:44] zero
);
  import spq_pkg::*;

  localparam int unsigned CountW = $clog2(Depth + 1);

  // Queue control.
  logic [CountW-1:0]   count_q, count_d;
  logic                accept;
  spq_op_e             op;
  logic                is_empty_now;
  logic                is_full_now;
  spq_cmd_t            cmd;

  // Result register.
  logic                out_valid_q;
  spq_status_e         status_q, status_d;
  logic [SpqDataW-1:0] value_out_q, value_out_d;
  logic [SpqCountW-1:0] entry_count_q;
  logic                is_empty_q, is_full_q;

  // Chain wiring.
  logic [SpqDataW-1:0] cell_val  [Depth];
  logic [SpqDataW-1:0] right_val [Depth];
  logic [SpqDataW-1:0] left_val  [Depth];
  logic                cell_gt   [Depth];
  logic                left_gt   [Depth];

  // Take a new item whenever the result register is free or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = spq_op_e'(s_axis_tuser);

  assign is_empty_now = count_q == '0;
  assign is_full_now  = count_q == CountW'(Depth);

  // Decode the operation; refused operations leave the chain alone.
  always_comb begin
    cmd.shift_in  = 1'b0;
    cmd.shift_out = 1'b0;
    cmd.value     = s_axis_tdata;
    count_d       = count_q;
    status_d      = StDone;
    value_out_d   = '0;
    case (op)
      OpEnqueue: begin
        if (is_full_now) begin
          status_d = StFull;
        end else begin
          cmd.shift_in = accept;
          count_d      = count_q + 1'b1;
        end
      end
      OpDequeue: begin
        if (is_empty_now) begin
          status_d = StEmpty;
        end else begin
          cmd.shift_out = accept;
          count_d       = count_q - 1'b1;
          value_out_d   = cell_val[0];
        end
      end
      OpPeek: begin
        if (is_empty_now) begin
          status_d = StEmpty;
        end else begin
          value_out_d = cell_val[0];
        end
      end
      OpClear: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  // Row of cells; head of the queue sits in cell 0.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_gt[i]  = 1'b0;
      assign left_val[i] = s_axis_tdata;
    end else begin : g_mid
      assign left_gt[i]  = cell_gt[i-1];
      assign left_val[i] = cell_val[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right_val[i] = cell_val[i];
    end else begin : g_body
      assign right_val[i] = cell_val[i+1];
    end

    spq_cell #(
      .Index  (i),
      .CountW (CountW)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .count_i     (count_q),
      .left_gt_i   (left_gt[i]),
      .left_val_i  (left_val[i]),
      .right_val_i (right_val[i]),
      .gt_o        (cell_gt[i]),
      .val_o       (cell_val[i])
    );
  end

  // Count: advance only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Output valid: set on accept, drop once the master side takes the item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: hold while stalled, load on accept.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q      <= status_d;
      value_out_q   <= value_out_d;
      entry_count_q <= SpqCountW'(count_d);
      is_empty_q    <= count_d == '0;
      is_full_q     <= count_d == CountW'(Depth);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, is_full_q, is_empty_q, entry_count_q, value_out_q, status_q};

  // Checks on the queue's own bookkeeping.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("count exceeds depth");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CountW'(2) |-> $signed(cell_val[0]) >= $signed(cell_val[1]))
    else $error("head entries out of order");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OpDequeue && !is_empty_now |=> count_q == $past(count_q) - 1'b1)
    else $error("dequeue did not lower count");

  a_full_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OpEnqueue && is_full_now |=> status_q == StFull && $stable(count_q))
    else $error("enqueue on full queue not refused");

endmodule
